// ===== rtl/core/dwb_pkg.sv =====
// shared types and constants for the depth window back-projection block
// no dependencies; used by dwb_div and depth_window_backprojection
package dwb_pkg;

  // depth frame geometry (powers of two)
  localparam int DEPTH_COLS = 256;
  localparam int DEPTH_ROWS = 256;
  localparam int COL_LOG2   = $clog2(DEPTH_COLS);
  localparam int ROW_LOG2   = $clog2(DEPTH_ROWS);
  localparam int COL_W      = COL_LOG2;
  localparam int ROW_W      = ROW_LOG2;

  // depth store
  localparam int STORE_AW   = 16;
  localparam int FULL_AW    = (COL_W + ROW_W > STORE_AW) ? COL_W + ROW_W : STORE_AW;

  // datapath widths
  localparam int CNT_W      = 15;
  localparam int SUM_W      = CNT_W + 8;
  localparam int NUM_W      = 44;
  localparam int DEN_W      = 23;
  localparam int HALF_W     = 12 + COL_LOG2;
  localparam int POS_W      = 28;

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 232;

  // configuration register indexes
  localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y = 3'd3;
  localparam logic [2:0] CFG_MIN_D    = 3'd4;
  localparam logic [2:0] CFG_MAX_D    = 3'd5;
  localparam logic [2:0] CFG_COLOR_W  = 3'd6;
  localparam logic [2:0] CFG_COLOR_H  = 3'd7;

  // item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE, S_PREP1, S_PREP2, S_DIV, S_WIN, S_WALK, S_DRAIN, S_FINISH
  } state_t;

  // division jobs in the order they run
  typedef enum logic [3:0] {
    JOB_CCOL, JOB_CROW, JOB_HW, JOB_HH, JOB_Z,
    JOB_PX, JOB_PY, JOB_LX, JOB_LY, JOB_HX, JOB_HY
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/core/dwb_div.sv =====
// iterative radix-2 divider with round-half-up quotient
// depends on dwb_pkg
module dwb_div (
  input  logic              clk,
  input  logic              rst,
  input  dwb_pkg::div_req_t req,
  output dwb_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(dwb_pkg::NUM_W + 1);

  logic                      busy;
  logic                      done;
  logic [CW-1:0]             cnt;
  logic [dwb_pkg::NUM_W-1:0] nq;
  logic [dwb_pkg::DEN_W-1:0] rem;
  logic [dwb_pkg::DEN_W-1:0] den;
  logic [dwb_pkg::DEN_W:0]   shifted;
  logic [dwb_pkg::DEN_W:0]   diff;
  logic                      ge;

  // one quotient bit per cycle
  always_comb begin
    shifted = {rem, nq[dwb_pkg::NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(dwb_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand registers; rounding bias added at load
  always_ff @(posedge clk) begin
    if (req.start) begin
      nq  <= req.num + dwb_pkg::NUM_W'(req.den >> 1);
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? diff[dwb_pkg::DEN_W-1:0] : shifted[dwb_pkg::DEN_W-1:0];
      nq  <= {nq[dwb_pkg::NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = nq;

endmodule

// ===== rtl/core/depth_window_backprojection.sv =====
// top level: depth frame store, window walk and pinhole back-projection
// depends on dwb_pkg and dwb_div
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  s_tuser kind,frame_start; s_tdata pixel and box
// m_*      out  m_tvalid / m_tready  m_tuser valid_res; m_tdata position fields
// cfg_*    in   cfg_valid/cfg_ready  cfg_addr register index, cfg_data value
//
// a store item is taken only while idle, so pixels stream at one per cycle between queries
// a query runs up to 11 divisions and reads each visited
// pixel (up to 16384) through the single read port of the depth store
// reset clears control state and loads config defaults; the store is not cleared
// results wait in an output register; a new item is taken meanwhile
module depth_window_backprojection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // depth_pixel[7:0], box_left[19:8], box_top[31:20], box_width[43:32], box_height[55:44]
  input  logic [dwb_pkg::IN_DATA_W-1:0]     s_tdata,
  // kind[0], frame_start[1]
  input  logic [dwb_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pos_x[27:0], pos_y[55:28], pos_z[75:56], sample_total[90:76], sample_col[102:91],
  // sample_row[114:103], low_x[142:115], low_y[170:143], high_x[198:171], high_y[226:199]
  output logic [dwb_pkg::OUT_DATA_W-1:0]    m_tdata,
  // valid_res[0]
  output logic                              m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_addr,
  input  logic [19:0]                       cfg_data
);

  localparam int CW = dwb_pkg::COL_W;
  localparam int RW = dwb_pkg::ROW_W;
  localparam int HW = dwb_pkg::HALF_W;
  localparam int PA_W = dwb_pkg::SUM_W + 16;

  // configuration registers
  logic [19:0] focal_x, focal_y, center_x, center_y;
  logic [15:0] min_depth, max_depth;
  logic [11:0] color_width, color_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= 20'd128000;
      focal_y      <= 20'd128000;
      center_x     <= 20'd81920;
      center_y     <= 20'd61440;
      min_depth    <= 16'd100;
      max_depth    <= 16'd4000;
      color_width  <= 12'd640;
      color_height <= 12'd480;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        dwb_pkg::CFG_FOCAL_X:  focal_x      <= cfg_data;
        dwb_pkg::CFG_FOCAL_Y:  focal_y      <= cfg_data;
        dwb_pkg::CFG_CENTER_X: center_x     <= cfg_data;
        dwb_pkg::CFG_CENTER_Y: center_y     <= cfg_data;
        dwb_pkg::CFG_MIN_D:    min_depth    <= cfg_data[15:0];
        dwb_pkg::CFG_MAX_D:    max_depth    <= cfg_data[15:0];
        dwb_pkg::CFG_COLOR_W:  color_width  <= cfg_data[11:0];
        dwb_pkg::CFG_COLOR_H:  color_height <= cfg_data[11:0];
      endcase
    end
  end

  // input item fields
  logic        in_kind, in_start;
  logic [7:0]  in_pixel;
  logic [11:0] in_left, in_top, in_bw, in_bh;
  assign in_kind  = s_tuser[0];
  assign in_start = s_tuser[1];
  assign in_pixel = s_tdata[7:0];
  assign in_left  = s_tdata[19:8];
  assign in_top   = s_tdata[31:20];
  assign in_bw    = s_tdata[43:32];
  assign in_bh    = s_tdata[55:44];

  dwb_pkg::state_t state, state_next;
  dwb_pkg::job_t   job;
  dwb_pkg::div_req_t div_req;
  dwb_pkg::div_rsp_t div_rsp;

  // latched query and intermediate values
  logic [11:0]               box_left, box_top, box_bw, box_bh;
  logic [CW-1:0]             ccol, x0, x1;
  logic [RW-1:0]             crow, y0, y1;
  logic [HW-1:0]             hw, hh;
  logic [CW:0]               wx;
  logic [RW:0]               wy;
  logic                      rd_pend;
  logic [7:0]                rd_data;
  logic [dwb_pkg::SUM_W-1:0] sum;
  logic [dwb_pkg::CNT_W-1:0] count;
  logic [PA_W-1:0]           pa;
  logic [19:0]               pcen;
  logic [dwb_pkg::DEN_W-1:0] pden;
  logic                      bneg;
  logic [19:0]               zq;
  logic                      res_ok;
  logic [27:0]               pos_x, pos_y, low_x, low_y, high_x, high_y;
  logic [15:0]               wr_ptr;

  logic bad_intr;
  assign bad_intr = (focal_x == '0) || (focal_y == '0) ||
                    (color_width == '0) || (color_height == '0);

  // window walk step
  logic [CW:0] wx_step;
  logic [RW:0] wy_step;
  logic        row_end, walk_end;
  always_comb begin
    wx_step  = wx + (CW+1)'(2);
    wy_step  = wy + (RW+1)'(2);
    row_end  = wx_step > {1'b0, x1};
    walk_end = row_end && (wy_step > {1'b0, y1});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dwb_pkg::S_IDLE:
        if (s_tvalid && in_kind == dwb_pkg::KIND_QUERY)
          state_next = bad_intr ? dwb_pkg::S_FINISH : dwb_pkg::S_PREP1;
      dwb_pkg::S_PREP1:
        if (job == dwb_pkg::JOB_Z && count == '0) state_next = dwb_pkg::S_FINISH;
        else state_next = dwb_pkg::S_PREP2;
      dwb_pkg::S_PREP2: state_next = dwb_pkg::S_DIV;
      dwb_pkg::S_DIV:
        if (div_rsp.done) begin
          if (job == dwb_pkg::JOB_HH) state_next = dwb_pkg::S_WIN;
          else if (job == dwb_pkg::JOB_HY) state_next = dwb_pkg::S_FINISH;
          else state_next = dwb_pkg::S_PREP1;
        end
      dwb_pkg::S_WIN:   state_next = dwb_pkg::S_WALK;
      dwb_pkg::S_WALK:  if (walk_end) state_next = dwb_pkg::S_DRAIN;
      dwb_pkg::S_DRAIN: state_next = dwb_pkg::S_PREP1;
      dwb_pkg::S_FINISH:
        if (!m_tvalid || m_tready) state_next = dwb_pkg::S_IDLE;
      default: state_next = dwb_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic out_load;
  always_comb begin
    s_tready = (state == dwb_pkg::S_IDLE);
    out_load = (state == dwb_pkg::S_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dwb_pkg::S_IDLE;
    else state <= state_next;
  end

  // depth store: one write port for pixels, one read port for the walk
  logic [7:0]                    mem [0:(1 << dwb_pkg::STORE_AW)-1];
  logic [dwb_pkg::STORE_AW-1:0]  wr_addr;
  logic [dwb_pkg::FULL_AW-1:0]   rd_full;
  logic                          st_en;
  assign st_en   = s_tvalid && s_tready && in_kind == dwb_pkg::KIND_STORE;
  assign wr_addr = in_start ? '0 : wr_ptr;
  assign rd_full = (dwb_pkg::FULL_AW'(wy[RW-1:0]) << dwb_pkg::COL_LOG2) +
                   dwb_pkg::FULL_AW'(wx[CW-1:0]);

  always_ff @(posedge clk) begin
    if (st_en) mem[wr_addr] <= in_pixel;
    rd_data <= mem[rd_full[dwb_pkg::STORE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) wr_ptr <= '0;
    else if (st_en) wr_ptr <= wr_addr + 1'b1;
  end

  // sample acceptance
  logic [23:0] pix_mm, thresh;
  logic        pix_ok;
  always_comb begin
    pix_mm = 24'(rd_data * max_depth);
    thresh = 24'(min_depth * 8'd255);
    pix_ok = pix_mm >= thresh;
  end

  // first operand stage: coordinate scaling for back-projection jobs
  logic [CW-1:0]           bp_c;
  logic [RW-1:0]           bp_r;
  logic                    bp_is_x;
  logic [CW+19:0]          ux_full;
  logic [RW+19:0]          uy_full;
  always_comb begin
    bp_c    = ccol;
    bp_r    = crow;
    bp_is_x = 1'b1;
    case (job)
      dwb_pkg::JOB_PY: bp_is_x = 1'b0;
      dwb_pkg::JOB_LX: bp_c = x0;
      dwb_pkg::JOB_LY: begin bp_r = y0; bp_is_x = 1'b0; end
      dwb_pkg::JOB_HX: bp_c = x1;
      dwb_pkg::JOB_HY: begin bp_r = y1; bp_is_x = 1'b0; end
      default: ;
    endcase
    ux_full = ({(CW+12)'(bp_c * color_width), 8'd0} +
               (CW+20)'(dwb_pkg::DEPTH_COLS / 2)) >> dwb_pkg::COL_LOG2;
    uy_full = ({(RW+12)'(bp_r * color_height), 8'd0} +
               (RW+20)'(dwb_pkg::DEPTH_ROWS / 2)) >> dwb_pkg::ROW_LOG2;
  end

  // second operand stage: numerator for the divider
  logic signed [20:0] bp_diff;
  logic [20:0]        bp_mag;
  always_comb begin
    bp_diff = $signed({1'b0, pa[19:0]}) - $signed({1'b0, pcen});
    bp_mag  = bp_diff[20] ? 21'(-bp_diff) : 21'(bp_diff);
    div_req.start = (state == dwb_pkg::S_PREP2);
    div_req.den   = pden;
    case (job)
      dwb_pkg::JOB_CCOL, dwb_pkg::JOB_HW:
        div_req.num = dwb_pkg::NUM_W'(pa) << dwb_pkg::COL_LOG2;
      dwb_pkg::JOB_CROW, dwb_pkg::JOB_HH:
        div_req.num = dwb_pkg::NUM_W'(pa) << dwb_pkg::ROW_LOG2;
      dwb_pkg::JOB_Z:
        div_req.num = dwb_pkg::NUM_W'(pa) << 4;
      default:
        div_req.num = dwb_pkg::NUM_W'(bp_mag * zq);
    endcase
  end

  dwb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // quotient post-processing
  logic [27:0] bp_sat;
  logic [dwb_pkg::NUM_W-1:0] q;
  always_comb begin
    q = div_rsp.quo;
    if (bneg)
      bp_sat = (q > dwb_pkg::NUM_W'(28'h8000000)) ? 28'h8000000 : 28'(-q);
    else
      bp_sat = (q > dwb_pkg::NUM_W'(28'h7FFFFFF)) ? 28'h7FFFFFF : q[27:0];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      job     <= dwb_pkg::JOB_CCOL;
    end else begin
      rd_pend <= (state == dwb_pkg::S_WALK);
      case (state)
        dwb_pkg::S_IDLE: job <= dwb_pkg::JOB_CCOL;
        dwb_pkg::S_DIV:
          if (div_rsp.done && job != dwb_pkg::JOB_HH && job != dwb_pkg::JOB_HY)
            job <= dwb_pkg::job_t'(job + 4'd1);
        dwb_pkg::S_DRAIN: job <= dwb_pkg::JOB_Z;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // sample accumulation in the cycle after each read
    if (rd_pend && pix_ok) begin
      sum   <= sum + dwb_pkg::SUM_W'(rd_data);
      count <= count + 1'b1;
    end
    case (state)
      dwb_pkg::S_IDLE: begin
        box_left <= in_left;
        box_top  <= in_top;
        box_bw   <= in_bw;
        box_bh   <= in_bh;
        res_ok   <= 1'b0;
      end
      dwb_pkg::S_PREP1: begin
        pcen <= center_x;
        pden <= dwb_pkg::DEN_W'(focal_x);
        pa   <= PA_W'(ux_full[19:0]);
        case (job)
          dwb_pkg::JOB_CCOL: begin
            pa   <= PA_W'({box_left, 1'b0} + {1'b0, box_bw});
            pden <= dwb_pkg::DEN_W'({color_width, 1'b0});
          end
          dwb_pkg::JOB_CROW: begin
            pa   <= PA_W'({box_top, 1'b0} + {1'b0, box_bh});
            pden <= dwb_pkg::DEN_W'({color_height, 1'b0});
          end
          dwb_pkg::JOB_HW: begin
            pa   <= PA_W'(box_bw);
            pden <= dwb_pkg::DEN_W'({color_width, 2'b0} + {2'b0, color_width});
          end
          dwb_pkg::JOB_HH: begin
            pa   <= PA_W'(box_bh);
            pden <= dwb_pkg::DEN_W'({color_height, 2'b0} + {2'b0, color_height});
          end
          dwb_pkg::JOB_Z: begin
            pa   <= PA_W'(sum * max_depth);
            pden <= dwb_pkg::DEN_W'({count, 8'd0} - {8'd0, count});
          end
          default:
            if (!bp_is_x) begin
              pa   <= PA_W'(uy_full[19:0]);
              pcen <= center_y;
              pden <= dwb_pkg::DEN_W'(focal_y);
            end
        endcase
      end
      dwb_pkg::S_PREP2: bneg <= bp_diff[20];
      dwb_pkg::S_DIV:
        if (div_rsp.done) begin
          case (job)
            dwb_pkg::JOB_CCOL:
              ccol <= (q > dwb_pkg::NUM_W'(dwb_pkg::DEPTH_COLS - 1)) ?
                      CW'(dwb_pkg::DEPTH_COLS - 1) : q[CW-1:0];
            dwb_pkg::JOB_CROW:
              crow <= (q > dwb_pkg::NUM_W'(dwb_pkg::DEPTH_ROWS - 1)) ?
                      RW'(dwb_pkg::DEPTH_ROWS - 1) : q[RW-1:0];
            dwb_pkg::JOB_HW: hw <= (q == '0) ? HW'(1) : q[HW-1:0];
            dwb_pkg::JOB_HH: hh <= (q == '0) ? HW'(1) : q[HW-1:0];
            dwb_pkg::JOB_Z: begin
              zq     <= q[19:0];
              res_ok <= 1'b1;
            end
            dwb_pkg::JOB_PX: pos_x  <= bp_sat;
            dwb_pkg::JOB_PY: pos_y  <= bp_sat;
            dwb_pkg::JOB_LX: low_x  <= bp_sat;
            dwb_pkg::JOB_LY: low_y  <= bp_sat;
            dwb_pkg::JOB_HX: high_x <= bp_sat;
            default:         high_y <= bp_sat;
          endcase
        end
      // window bounds, clamped to the frame
      dwb_pkg::S_WIN: begin
        x0 <= (hw >= HW'(ccol)) ? '0 : CW'(HW'(ccol) - hw);
        y0 <= (hh >= HW'(crow)) ? '0 : RW'(HW'(crow) - hh);
        x1 <= ((HW+1)'(ccol) + (HW+1)'(hw) > (HW+1)'(dwb_pkg::DEPTH_COLS - 1)) ?
              CW'(dwb_pkg::DEPTH_COLS - 1) : CW'(HW'(ccol) + hw);
        y1 <= ((HW+1)'(crow) + (HW+1)'(hh) > (HW+1)'(dwb_pkg::DEPTH_ROWS - 1)) ?
              RW'(dwb_pkg::DEPTH_ROWS - 1) : RW'(HW'(crow) + hh);
        sum   <= '0;
        count <= '0;
        wx    <= (hw >= HW'(ccol)) ? '0 : (CW+1)'(HW'(ccol) - hw);
        wy    <= (hh >= HW'(crow)) ? '0 : (RW+1)'(HW'(crow) - hh);
      end
      // raster walk over every second row and column
      dwb_pkg::S_WALK:
        if (row_end) begin
          wx <= {1'b0, x0};
          wy <= wy_step;
        end else begin
          wx <= wx_step;
        end
      default: ;
    endcase
  end

  // output register
  logic [11:0] s_col, s_row;
  always_comb begin
    s_col = 12'((CW+12)'(ccol * color_width) + (CW+12)'(dwb_pkg::DEPTH_COLS / 2)
                >> dwb_pkg::COL_LOG2);
    s_row = 12'((RW+12)'(crow * color_height) + (RW+12)'(dwb_pkg::DEPTH_ROWS / 2)
                >> dwb_pkg::ROW_LOG2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_ok;
      if (res_ok)
        m_tdata <= {5'd0, high_y, high_x, low_y, low_x, s_row, s_col,
                    count, zq, pos_y, pos_x};
      else
        m_tdata <= '0;
    end
  end

endmodule
